// ===== hdl/bounded_length_max_subarray_sum_core_defines.svh =====
// Assertion shorthands for the bounded run-sum core.
`ifndef BOUNDED_LENGTH_MAX_SUBARRAY_SUM_CORE_DEFINES_SVH
`define BOUNDED_LENGTH_MAX_SUBARRAY_SUM_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define BLMSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blmss assertion failed");

// next-cycle implication
`define BLMSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blmss assertion failed");

`endif

// ===== hdl/blmss_pkg.sv =====
package blmss_pkg;

  localparam int LEN_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 48;
  localparam int PREFIX_W  = 64;
  localparam int COUNT_W   = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEN = 2'd0,
    REG_MAX_LEN = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_PUSHCHK,
    S_BACKCMP,
    S_HEADRD,
    S_HEADCMP,
    S_BEST,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic init_ring;
    logic latch_pnew;
    logic rd_back;
    logic drop_back;
    logic push;
    logic pop_head;
    logic latch_cand;
    logic update_best;
    logic emit;
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic en;
    logic seen_ge_lo;
    logic dq_empty;
    logic push_ok;
    logic back_lt;
    logic head_old;
    logic head_last;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/blmss_ram.sv =====
module blmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/blmss_ctrl.sv =====
`include "bounded_length_max_subarray_sum_core_defines.svh"

module blmss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  blmss_pkg::sts_t sts,
  output blmss_pkg::cmd_t cmd
);
  import blmss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_INIT: begin
        cmd.init_ring = 1'b1;
        state_next    = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.rd_back = 1'b1;
        priority if (!sts.en) begin
          state_next = S_FINISH;
        end else if (sts.seen_ge_lo) begin
          state_next = S_PUSHCHK;
        end else begin
          state_next = S_HEADRD;
        end
      end
      S_PUSHCHK: begin
        cmd.latch_pnew = 1'b1;
        if (sts.push_ok) begin
          cmd.rd_back = 1'b1;
          state_next  = S_BACKCMP;
        end else begin
          state_next = S_HEADRD;
        end
      end
      S_BACKCMP: begin
        if (sts.dq_empty || sts.back_lt) begin
          cmd.push   = 1'b1;
          state_next = S_HEADRD;
        end else begin
          cmd.drop_back = 1'b1;
          cmd.rd_back   = 1'b1;
        end
      end
      S_HEADRD: begin
        state_next = sts.dq_empty ? S_FINISH : S_HEADCMP;
      end
      S_HEADCMP: begin
        if (sts.head_old) begin
          cmd.pop_head = 1'b1;
          if (sts.head_last) begin
            state_next = S_FINISH;
          end
        end else begin
          cmd.latch_cand = 1'b1;
          state_next     = S_BEST;
        end
      end
      S_BEST: begin
        cmd.update_best = 1'b1;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        priority if (!sts.last) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.restart = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BLMSS_ASSERT_NEXT(a_accept_starts, (in_valid && !in_stall), state == S_START)
  `BLMSS_ASSERT_IMP(a_emit_on_last, cmd.emit, sts.last && sts.out_free)
  `BLMSS_ASSERT_NEXT(a_emit_returns_idle, cmd.emit, state == S_IDLE)

endmodule

// ===== hdl/blmss_dp.sv =====
`include "bounded_length_max_subarray_sum_core_defines.svh"

module blmss_dp #(
  parameter int MAX_WINDOW = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [blmss_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  last,
  input  logic                                  cfg_valid,
  input  logic [blmss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [blmss_pkg::LEN_W-1:0]           cfg_data,
  input  blmss_pkg::cmd_t                       cmd,
  output blmss_pkg::sts_t                       sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [blmss_pkg::SUM_W-1:0]    best_sum,
  output logic                                  found
);
  import blmss_pkg::*;

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int DQ_W  = COUNT_W + PREFIX_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  logic [LEN_W-1:0]    min_len;
  logic [LEN_W-1:0]    max_len;
  logic [PREFIX_W-1:0] prefix_total;
  logic [PTR_W-1:0]    ring_pos;
  logic [COUNT_W-1:0]  item_count;
  logic [PTR_W-1:0]    seen;
  logic [PTR_W-1:0]    deque_head;
  logic [PTR_W-1:0]    deque_tail;
  logic                last_q;
  logic [PREFIX_W-1:0] pnew;
  logic [SUM_W-1:0]    cand;
  logic [SUM_W-1:0]    running_best;
  logic                best_valid;

  logic [COUNT_W-1:0]  min32;
  logic [COUNT_W-1:0]  max32;
  logic [COUNT_W-1:0]  lo32;
  logic [COUNT_W-1:0]  hi32;
  logic [PTR_W-1:0]    lo;
  logic [PTR_W-1:0]    hi;
  logic [PREFIX_W-1:0] sample_ext;
  logic [PREFIX_W-1:0] prefix_sum;

  logic                ring_we;
  logic [PTR_W-1:0]    ring_waddr;
  logic [PREFIX_W-1:0] ring_wdata;
  logic [PTR_W:0]      ring_back;
  logic [PTR_W-1:0]    ring_raddr;
  logic [PREFIX_W-1:0] ring_rdata;

  logic [PTR_W-1:0]    dq_raddr;
  logic [DQ_W-1:0]     dq_rdata;
  logic [COUNT_W-1:0]  ent_idx;
  logic [PREFIX_W-1:0] ent_prefix;
  logic [COUNT_W-1:0]  ent_age;
  logic [PREFIX_W-1:0] ent_eff;
  logic [PREFIX_W-1:0] back_diff;
  logic [PREFIX_W-1:0] run_full;
  logic [SUM_W-1:0]    run_sat;
  logic [COUNT_W-1:0]  idx_new;

  // effective lengths
  assign min32 = COUNT_W'(min_len);
  assign max32 = COUNT_W'(max_len);
  always_comb begin
    priority if (min32 == '0) begin
      lo32 = COUNT_W'(1);
    end else if (min32 > COUNT_W'(MAX_WINDOW)) begin
      lo32 = COUNT_W'(MAX_WINDOW);
    end else begin
      lo32 = min32;
    end
    hi32 = (max32 > COUNT_W'(MAX_WINDOW)) ? COUNT_W'(MAX_WINDOW) : max32;
  end
  assign lo = lo32[PTR_W-1:0];
  assign hi = hi32[PTR_W-1:0];

  assign sample_ext = {{(PREFIX_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
  assign prefix_sum = prefix_total + sample_ext;

  // prefix ring: slot 0 holds the empty prefix at sequence start
  assign ring_we    = cmd.accept | cmd.init_ring | cmd.restart;
  assign ring_waddr = cmd.accept ? ptr_inc(ring_pos) : '0;
  assign ring_wdata = cmd.accept ? prefix_sum : '0;
  assign ring_back  = ({1'b0, ring_pos} >= {1'b0, lo}) ?
                      {1'b0, ring_pos} - {1'b0, lo} :
                      {1'b0, ring_pos} + (PTR_W+1)'(DEPTH) - {1'b0, lo};
  assign ring_raddr = ring_back[PTR_W-1:0];

  blmss_ram #(
    .WIDTH(PREFIX_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_waddr),
    .wdata(ring_wdata),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  // deque entries carry the index and its prefix
  always_comb begin
    if (cmd.rd_back) begin
      dq_raddr = cmd.drop_back ? ptr_dec(ptr_dec(deque_tail)) : ptr_dec(deque_tail);
    end else begin
      dq_raddr = cmd.pop_head ? ptr_inc(deque_head) : deque_head;
    end
  end

  assign idx_new = item_count - lo32;

  blmss_ram #(
    .WIDTH(DQ_W),
    .DEPTH(DEPTH)
  ) u_deque (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(deque_tail),
    .wdata({idx_new, pnew}),
    .raddr(dq_raddr),
    .rdata(dq_rdata)
  );

  assign ent_idx    = dq_rdata[DQ_W-1:PREFIX_W];
  assign ent_prefix = dq_rdata[PREFIX_W-1:0];
  assign ent_age    = item_count - ent_idx;
  // an entry one full ring old aliases the current slot
  assign ent_eff    = (ent_age == COUNT_W'(DEPTH)) ? prefix_total : ent_prefix;
  assign back_diff  = ent_eff - pnew;
  assign run_full   = prefix_total - ent_eff;

  always_comb begin
    if ((&run_full[PREFIX_W-1:SUM_W-1]) || !(|run_full[PREFIX_W-1:SUM_W-1])) begin
      run_sat = run_full[SUM_W-1:0];
    end else begin
      run_sat = run_full[PREFIX_W-1] ? SUM_MIN : SUM_MAX;
    end
  end

  always_comb begin
    sts.en         = hi >= lo;
    sts.seen_ge_lo = seen >= lo;
    sts.dq_empty   = deque_head == deque_tail;
    sts.push_ok    = (deque_head == deque_tail) || (ent_age > lo32);
    sts.back_lt    = back_diff[PREFIX_W-1];
    sts.head_old   = ent_age > hi32;
    sts.head_last  = ptr_inc(deque_head) == deque_tail;
    sts.last       = last_q;
    sts.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= LEN_W'(1);
      max_len <= LEN_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_MIN_LEN) begin
        min_len <= cfg_data;
      end
      if (cfg_index == REG_MAX_LEN) begin
        max_len <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      prefix_total <= '0;
      ring_pos     <= '0;
      item_count   <= '0;
      seen         <= '0;
      deque_head   <= '0;
      deque_tail   <= '0;
      running_best <= SUM_MIN;
      best_valid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        prefix_total <= prefix_sum;
        ring_pos     <= ptr_inc(ring_pos);
        item_count   <= item_count + 1'b1;
        if (seen != PTR_W'(MAX_WINDOW)) begin
          seen <= seen + 1'b1;
        end
      end
      if (cmd.drop_back) begin
        deque_tail <= ptr_dec(deque_tail);
      end
      if (cmd.push) begin
        deque_tail <= ptr_inc(deque_tail);
      end
      if (cmd.pop_head) begin
        deque_head <= ptr_inc(deque_head);
      end
      if (cmd.update_best) begin
        if (!best_valid || ($signed(cand) > $signed(running_best))) begin
          running_best <= cand;
        end
        best_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_q <= last;
    end
    if (cmd.latch_pnew) begin
      pnew <= ring_rdata;
    end
    if (cmd.latch_cand) begin
      cand <= run_sat;
    end
    if (cmd.emit) begin
      best_sum <= best_valid ? running_best : '0;
      found    <= best_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `BLMSS_ASSERT_NEXT(a_restart_clears, cmd.restart, deque_head == deque_tail && !best_valid)
  `BLMSS_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)
  `BLMSS_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(best_sum) && $stable(found))

endmodule

// ===== hdl/bounded_length_max_subarray_sum_core.sv =====
// Channel  Direction  Handshake            Beat contents
// in       sink       in_valid / in_stall  sample, last
// out      source     out_valid / out_stall best_sum, found
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data (0 min_len, 1 max_len)
//
// Each deque entry dropped from either end adds a step to a sample's processing;
// drops average at most one per sample, each using the deque RAM port.
// Reset is synchronous; the init state entered on reset seeds the prefix ring.
// A result beat waits in the output register; a further sample is taken meanwhile,
// but the next last-marked sample is held in its finish state until that beat is taken.
module bounded_length_max_subarray_sum_core #(
  parameter int MAX_WINDOW = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [blmss_pkg::SAMPLE_W-1:0] sample,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [blmss_pkg::SUM_W-1:0]    best_sum,
  output logic                                  found,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [blmss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [blmss_pkg::LEN_W-1:0]           cfg_data
);
  import blmss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  blmss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  blmss_dp #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .last     (last),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .best_sum (best_sum),
    .found    (found)
  );

endmodule
